// ----- rtl/core/ucb_pkg.sv -----
// shared types, constants and tables for the ucb1 arm selector
`default_nettype none
package ucb_pkg;

	localparam int MAX_ARMS = 16;
	localparam int ARM_W    = $clog2(MAX_ARMS);
	localparam int NARM_W   = $clog2(MAX_ARMS + 1);
	localparam int CNT_W    = 24;
	localparam int SUM_W    = 40;
	localparam int LN_W     = 21;
	localparam int DVD_W    = 48;
	localparam int MEAN_W   = DVD_W + 1;
	localparam int SQ_W     = 38;
	localparam int ROOT_W   = SQ_W / 2;
	localparam int BON_W    = ROOT_W + 8 - 4;
	localparam int SCORE_W  = MEAN_W + 1;
	localparam int E_W      = 5;
	localparam logic [15:0] LN2_Q16 = 16'd45426;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic REG_GAIN = 1'b0;
	localparam logic REG_ARMS = 1'b1;

	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_REWARD = 1'b1;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_UPD  = 9'b000000010,
		ST_SCAN = 9'b000000100,
		ST_MDIV = 9'b000001000,
		ST_QDIV = 9'b000010000,
		ST_SQRT = 9'b000100000,
		ST_BON  = 9'b001000000,
		ST_CMP  = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	typedef struct packed {
		logic take;
		logic clear;
		logic update;
		logic pick_first;
		logic load_mean;
		logic run_div;
		logic load_q;
		logic load_sqrt;
		logic run_sqrt;
		logic bonus;
		logic compare;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic initial_rnd;
		logic div_done;
		logic sqrt_done;
		logic last;
		logic out_free;
	} status_t;

	// fractional part of ln(1 + f/16) in q16.16
	function automatic logic [15:0] ln_frac(input logic [3:0] f);
		logic [15:0] r;
		case (f)
			4'd0:    r = 16'd0;
			4'd1:    r = 16'd3973;
			4'd2:    r = 16'd7719;
			4'd3:    r = 16'd11262;
			4'd4:    r = 16'd14624;
			4'd5:    r = 16'd17821;
			4'd6:    r = 16'd20870;
			4'd7:    r = 16'd23783;
			4'd8:    r = 16'd26573;
			4'd9:    r = 16'd29248;
			4'd10:   r = 16'd31818;
			4'd11:   r = 16'd34292;
			4'd12:   r = 16'd36675;
			4'd13:   r = 16'd38975;
			4'd14:   r = 16'd41196;
			default: r = 16'd43345;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ucb_ctrl.sv -----
// sequencer for update, scoring and result hand-off
`default_nettype none
module ucb_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             command,
	input  wire ucb_pkg::status_t st,
	output ucb_pkg::cmd_t         cmd,
	output logic                  busy
);
	import ucb_pkg::*;

	state_t state_q, nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		cmd = '0;
		nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (command == CMD_START) begin
						cmd.clear = 1'b1;
						nxt = ST_DONE;
					end else begin
						nxt = ST_UPD;
					end
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (st.initial_rnd) begin
					cmd.pick_first = 1'b1;
					nxt = ST_DONE;
				end else begin
					cmd.load_mean = 1'b1;
					nxt = ST_MDIV;
				end
			end
			ST_MDIV: begin
				if (st.div_done) begin
					cmd.load_q = 1'b1;
					nxt = ST_QDIV;
				end else begin
					cmd.run_div = 1'b1;
				end
			end
			ST_QDIV: begin
				if (st.div_done) begin
					cmd.load_sqrt = 1'b1;
					nxt = ST_SQRT;
				end else begin
					cmd.run_div = 1'b1;
				end
			end
			ST_SQRT: begin
				if (st.sqrt_done) begin
					nxt = ST_BON;
				end else begin
					cmd.run_sqrt = 1'b1;
				end
			end
			ST_BON: begin
				cmd.bonus = 1'b1;
				nxt = ST_CMP;
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				nxt = st.last ? ST_DONE : ST_SCAN;
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					nxt = ST_IDLE;
				end
			end
			default: nxt = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/ucb_dp.sv -----
// arm statistics, shared divider, square root and score compare
`default_nettype none
module ucb_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ucb_pkg::cmd_t      cmd,
	output ucb_pkg::status_t        st,
	input  wire logic signed [15:0] reward,
	input  wire logic [7:0]         gain,
	input  wire logic [4:0]         arms_in_use,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [3:0]              next_arm,
	output logic                    initial_round
);
	import ucb_pkg::*;

	logic signed [SUM_W-1:0] sum_q [MAX_ARMS];
	logic [CNT_W-1:0]        cnt_q [MAX_ARMS];
	logic [MAX_ARMS-1:0]     vld_q;
	logic [CNT_W-1:0]        total_q;
	logic [ARM_W-1:0]        last_q, i_q, best_idx_q, res_arm_q;
	logic                    res_init_q, out_valid_q;
	logic signed [15:0]      rwd_q;
	logic [LN_W-1:0]         ln_q;
	logic [DVD_W-1:0]        quo_q;
	logic [CNT_W-1:0]        rem_q, dvs_q;
	logic [5:0]              dcnt_q;
	logic                    neg_q;
	logic signed [MEAN_W-1:0] mean_q;
	logic [SQ_W-1:0]         sq_q;
	logic [ROOT_W+2:0]       srem_q;
	logic [ROOT_W-1:0]       root_q;
	logic [4:0]              scnt_q;
	logic [BON_W-1:0]        bon_q;
	logic signed [SCORE_W-1:0] best_q;

	// active arm count
	logic [NARM_W-1:0] n_act;
	always_comb begin
		if (arms_in_use == 5'd0) begin
			n_act = NARM_W'(1);
		end else if (32'(arms_in_use) > MAX_ARMS) begin
			n_act = NARM_W'(MAX_ARMS);
		end else begin
			n_act = NARM_W'(arms_in_use);
		end
	end

	// reads of arm statistics, invalid entries read as zero
	logic signed [SUM_W-1:0] sum_l, sum_i;
	logic [CNT_W-1:0]        cnt_l, cnt_i;
	assign sum_l = vld_q[last_q] ? sum_q[last_q] : '0;
	assign cnt_l = vld_q[last_q] ? cnt_q[last_q] : '0;
	assign sum_i = vld_q[i_q] ? sum_q[i_q] : '0;
	assign cnt_i = vld_q[i_q] ? cnt_q[i_q] : '0;

	// saturating reward add
	logic signed [SUM_W:0]   sum_ext;
	logic signed [SUM_W-1:0] sum_new;
	always_comb begin
		sum_ext = {sum_l[SUM_W-1], sum_l} + (SUM_W+1)'(rwd_q);
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_new = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_new = sum_ext[SUM_W-1:0];
		end
	end

	// lowest unpulled arm in use
	logic [ARM_W-1:0] first_idx;
	logic             first_fnd;
	always_comb begin
		first_idx = '0;
		first_fnd = 1'b0;
		for (int j = MAX_ARMS - 1; j >= 0; j--) begin
			if (NARM_W'(j) < n_act && !vld_q[j]) begin
				first_idx = ARM_W'(j);
				first_fnd = 1'b1;
			end
		end
	end

	// table-based ln of the total pull count
	logic [E_W-1:0] e_pos;
	logic [3:0]     f_bits;
	logic [LN_W-1:0] ln_val;
	always_comb begin
		e_pos = '0;
		for (int j = 0; j < CNT_W; j++) begin
			if (total_q[j]) begin
				e_pos = E_W'(j);
			end
		end
		if (e_pos >= E_W'(4)) begin
			f_bits = 4'(total_q >> (e_pos - E_W'(4)));
		end else begin
			f_bits = 4'(total_q << (E_W'(4) - e_pos));
		end
		ln_val = LN_W'(e_pos) * LN_W'(LN2_Q16) + LN_W'(ln_frac(f_bits));
	end

	// divider step
	logic [CNT_W+1:0] dtrial;
	logic             dge;
	assign dtrial = {1'b0, rem_q, quo_q[DVD_W-1]} - {2'b00, dvs_q};
	assign dge    = !dtrial[CNT_W+1];

	// square root step
	logic [ROOT_W+2:0] sshift, strial;
	logic              sge;
	assign sshift = {srem_q[ROOT_W:0], sq_q[SQ_W-1:SQ_W-2]};
	assign strial = {root_q, 2'b01};
	assign sge    = (sshift >= strial);

	// exploration bonus product
	logic [ROOT_W+7:0] bon_prod;
	assign bon_prod = (ROOT_W+8)'(gain) * (ROOT_W+8)'(root_q);

	// score of current arm
	logic signed [SCORE_W-1:0] score;
	logic                      take_it;
	assign score   = {mean_q[MEAN_W-1], mean_q} + SCORE_W'(bon_q);
	assign take_it = (i_q == '0) || (score > best_q);

	// sum magnitude for the mean division
	logic [SUM_W-1:0] sum_mag;
	assign sum_mag = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);

	// arm statistics
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			sum_q[last_q] <= sum_new;
			cnt_q[last_q] <= (cnt_l == CNT_MAX) ? cnt_l : cnt_l + 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			total_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
			dcnt_q      <= '0;
			scnt_q      <= '0;
			i_q         <= '0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				last_q      <= res_arm_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.clear) begin
				vld_q   <= '0;
				total_q <= '0;
			end
			if (cmd.update) begin
				vld_q[last_q] <= 1'b1;
				if (total_q != CNT_MAX) begin
					total_q <= total_q + 1'b1;
				end
				i_q <= '0;
			end
			if (cmd.load_mean || cmd.load_q) begin
				dcnt_q <= '0;
			end else if (cmd.run_div) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.load_sqrt) begin
				scnt_q <= '0;
			end else if (cmd.run_sqrt) begin
				scnt_q <= scnt_q + 1'b1;
			end
			if (cmd.compare) begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rwd_q <= reward;
		end
		if (cmd.clear) begin
			res_arm_q  <= '0;
			res_init_q <= 1'b1;
		end
		if (cmd.pick_first) begin
			res_arm_q  <= first_idx;
			res_init_q <= 1'b1;
		end
		if (cmd.load_mean) begin
			ln_q  <= ln_val;
			neg_q <= sum_i[SUM_W-1];
			quo_q <= {sum_mag, 8'b0};
			rem_q <= '0;
			dvs_q <= cnt_i;
		end else if (cmd.load_q) begin
			mean_q <= neg_q ? -MEAN_W'(quo_q) : MEAN_W'(quo_q);
			quo_q  <= DVD_W'(ln_q);
			rem_q  <= '0;
		end else if (cmd.run_div) begin
			rem_q <= dge ? dtrial[CNT_W-1:0] : {rem_q[CNT_W-2:0], quo_q[DVD_W-1]};
			quo_q <= {quo_q[DVD_W-2:0], dge};
		end
		if (cmd.load_sqrt) begin
			sq_q   <= {1'b0, quo_q[LN_W-1:0], 16'b0};
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.run_sqrt) begin
			sq_q   <= {sq_q[SQ_W-3:0], 2'b00};
			srem_q <= sge ? sshift - strial : sshift;
			root_q <= {root_q[ROOT_W-2:0], sge};
		end
		if (cmd.bonus) begin
			bon_q <= bon_prod[ROOT_W+7:4];
		end
		if (cmd.compare) begin
			if (take_it) begin
				best_q     <= score;
				best_idx_q <= i_q;
			end
			res_arm_q  <= take_it ? i_q : best_idx_q;
			res_init_q <= 1'b0;
		end
		if (cmd.emit) begin
			next_arm      <= 4'(res_arm_q);
			initial_round <= res_init_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign st.initial_rnd = first_fnd;
	assign st.div_done    = (dcnt_q == 6'(DVD_W));
	assign st.sqrt_done   = (scnt_q == 5'(ROOT_W));
	assign st.last        = ({1'b0, i_q} == n_act - 1'b1);
	assign st.out_free    = !out_valid_q || !out_stall;

endmodule
`default_nettype wire

// ----- rtl/core/ucb_bandit_arm_selector.sv -----
// ucb1 arm selector top level: config registers, sequencer and datapath
// a start word goes straight to the result; a reward word updates the statistics and,
// during the first round, picks the lowest unpulled arm; otherwise each arm in use is
// scored in turn by two 48-step divisions and a 19-step root in one shared unit.
// one word in work at a time; a finished result waits in the output register
// while the next word is taken. reset clears all arm statistics, config to defaults
`default_nettype none
module ucb_bandit_arm_selector (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [15:0] reward,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       next_arm,
	output logic             initial_round,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import ucb_pkg::*;

	logic [7:0] gain_q;
	logic [4:0] arms_q;
	cmd_t       cmd;
	status_t    st;
	logic       busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 8'd32;
			arms_q <= 5'd16;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_GAIN) begin
				gain_q <= pwdata[7:0];
			end else begin
				arms_q <= pwdata[4:0];
			end
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ARMS) ? {27'b0, arms_q} : {24'b0, gain_q};
	assign in_stall = busy;

	ucb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy)
	);

	ucb_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.reward        (reward),
		.gain          (gain_q),
		.arms_in_use   (arms_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.next_arm      (next_arm),
		.initial_round (initial_round)
	);

endmodule
`default_nettype wire

// ----- rtl/core/ucb_chk.sv -----
// port-level checks for the ucb1 arm selector and their binding
`default_nettype none
module ucb_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       command,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [3:0] next_arm,
	input wire logic       initial_round
);
	import ucb_pkg::*;

	// one word in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("word taken while previous one still in work");

	// held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_arm) && $stable(initial_round))
		else $error("stalled result changed");

	// start word names arm zero in the first round
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == CMD_START) && !out_valid
		|=> ##1 (out_valid && initial_round && next_arm == 4'd0))
		else $error("start word gave wrong result");

endmodule

bind ucb_bandit_arm_selector ucb_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.command       (command),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.next_arm      (next_arm),
	.initial_round (initial_round)
);
`default_nettype wire

// ----- verif/ucb_bandit_arm_selector_tb.sv -----
// self-checking testbench for the ucb1 arm selector: random words, config phases, scoreboard
`default_nettype none
module ucb_bandit_arm_selector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ucb_pkg::*;

	localparam logic [2:0] ADDR_GAIN = 3'd0;
	localparam logic [2:0] ADDR_ARMS = 3'd4;
	localparam int ARM_COUNT = 16;
	localparam longint SUM_HI = 64'sd549755813887;
	localparam longint SUM_LO = -64'sd549755813888;
	localparam longint unsigned PULL_MAX = (64'd1 << 24) - 1;
	localparam longint unsigned LN2_FIX = 45426;
	localparam int LONG_HOLD = 3000;
	localparam int DRAIN_WAIT = 2000;
	localparam longint CYCLE_LIMIT = 20000000;

	typedef struct packed {
		logic        cmd;
		logic [15:0] rew;
	} word_t;

	typedef struct packed {
		logic [3:0] arm;
		logic       first_round;
	} pick_t;

	localparam longint unsigned LN_TAB [16] = '{
		0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
		26573, 29248, 31818, 34292, 36675, 38975, 41196, 43345
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = CMD_START;
	logic [15:0] reward = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  next_arm;
	logic        initial_round;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	ucb_bandit_arm_selector u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .command(command), .reward(reward),
		.out_valid(out_valid), .out_stall(out_stall),
		.next_arm(next_arm), .initial_round(initial_round),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	longint          arm_sum [ARM_COUNT];
	longint unsigned arm_pulls [ARM_COUNT];
	longint unsigned all_pulls;
	int unsigned     prev_arm;
	int unsigned     gain_q44;
	int unsigned     arms_reg;

	word_t pending_words[$];
	pick_t expected_picks[$];
	int    errors = 0;
	longint cycles = 0;
	bit    calm_in = 0;
	bit    calm_out = 0;
	bit    hold_req = 0;
	bit    hold_on = 0;
	bit    hold_done = 0;
	int    hold_left = 0;
	int    in_gap = 0;
	int    out_gap = 0;
	int    words_queued = 0;
	int    words_taken = 0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ln in q16.16 from leading one and four bits below it
	function automatic longint unsigned ln_fix(input longint unsigned x);
		int e;
		logic [3:0] f;
		if (x == 0)
			return 0;
		e = 0;
		while (e < 63 && (x >> (e + 1)) != 0)
			e++;
		if (e >= 4)
			f = 4'(x >> (e - 4));
		else
			f = 4'(x << (4 - e));
		return longint'(e) * LN2_FIX + LN_TAB[f];
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void clear_stats();
		for (int i = 0; i < ARM_COUNT; i++) begin
			arm_sum[i] = 0;
			arm_pulls[i] = 0;
		end
		all_pulls = 0;
		prev_arm = 0;
	endfunction

	// next arm choice for one accepted word
	function automatic pick_t choose_arm(input word_t w);
		pick_t p;
		int unsigned n;
		int unsigned a;
		int unsigned best;
		bit first;
		longint s;
		longint best_score;
		longint score;
		longint unsigned lnv;
		longint unsigned c;
		longint unsigned q;
		if (w.cmd == CMD_START) begin
			clear_stats();
			p.arm = 4'd0;
			p.first_round = 1'b1;
			return p;
		end
		a = prev_arm % ARM_COUNT;
		s = arm_sum[a] + longint'($signed(w.rew));
		if (s > SUM_HI)
			s = SUM_HI;
		if (s < SUM_LO)
			s = SUM_LO;
		arm_sum[a] = s;
		if (arm_pulls[a] < PULL_MAX)
			arm_pulls[a]++;
		if (all_pulls < PULL_MAX)
			all_pulls++;
		n = (arms_reg == 0) ? 1 : (arms_reg > ARM_COUNT) ? ARM_COUNT : arms_reg;
		first = 0;
		best = 0;
		best_score = 0;
		for (int i = 0; i < n; i++) begin
			if (!first && arm_pulls[i] == 0) begin
				first = 1;
				best = i;
			end
		end
		if (!first) begin
			lnv = ln_fix(all_pulls);
			for (int i = 0; i < n; i++) begin
				c = arm_pulls[i];
				q = lnv / c;
				score = (arm_sum[i] * 256) / longint'(c)
					+ longint'((longint'(gain_q44) * root_floor(q << 16)) >> 4);
				if (i == 0 || score > best_score) begin
					best_score = score;
					best = i;
				end
			end
		end
		prev_arm = best;
		p.arm = 4'(best);
		p.first_round = first;
		return p;
	endfunction

	// driver: offer queued words with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				expected_picks.insert(expected_picks.size(), choose_arm('{command, reward}));
				words_taken++;
			end
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				command <= pending_words[0].cmd;
				reward <= pending_words[0].rew;
				void'(pending_words.pop_front());
				in_valid <= 1'b1;
				in_gap <= calm_in ? 0 : $urandom_range(0, 13);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_on) begin
			if (hold_left == 0) begin
				hold_on <= 1'b0;
				hold_done <= 1'b1;
			end else begin
				hold_left <= hold_left - 1;
			end
		end else if (hold_req && !hold_done) begin
			hold_on <= 1'b1;
			hold_left <= LONG_HOLD;
		end
	end

	// monitor: random stalls and result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_picks.size() == 0) begin
					if (errors < 10)
						$display("unexpected word: arm %0d first %0b", next_arm, initial_round);
					errors++;
				end else begin
					if (next_arm !== expected_picks[0].arm
						|| initial_round !== expected_picks[0].first_round) begin
						if (errors < 10)
							$display("mismatch: arm exp %0d got %0d, first exp %0b got %0b",
								expected_picks[0].arm, next_arm,
								expected_picks[0].first_round, initial_round);
						errors++;
					end
					void'(expected_picks.pop_front());
				end
				out_gap <= calm_out ? 0 : $urandom_range(0, 13);
				out_stall <= hold_on || (!calm_out && $urandom_range(0, 1));
			end else begin
				if (out_gap > 0)
					out_gap <= out_gap - 1;
				out_stall <= hold_on || (out_gap > 1);
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("ucb_bandit_arm_selector_tb: FAIL");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_GAIN)
			gain_q44 = data[7:0];
		else
			arms_reg = data[4:0];
	endtask

	// every queued word taken and every result seen
	task automatic wait_drained();
		while (words_taken < words_queued || expected_picks.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_word(input logic cmd, input logic [15:0] rew);
		word_t w;
		w.cmd = cmd;
		w.rew = rew;
		pending_words.insert(pending_words.size(), w);
		words_queued++;
	endtask

	function automatic logic [15:0] pick_reward();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3, 4, 5: return 16'($urandom);
			default: return 16'($urandom_range(0, 1536) - 512);
		endcase
	endfunction

	// one phase: set registers while idle, then a burst of reward words with optional start words
	task automatic run_phase(input int unsigned gain, input int unsigned arms,
		input int count, input bit restart);
		wait_drained();
		apb_write(ADDR_GAIN, gain);
		apb_write(ADDR_ARMS, arms);
		if (restart)
			queue_word(CMD_START, 16'($urandom));
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) == 0)
				queue_word(CMD_START, 16'($urandom));
			else
				queue_word(CMD_REWARD, pick_reward());
		end
	endtask

	initial begin
		int ph;
		gain_q44 = 32;
		arms_reg = 16;
		clear_stats();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: extremes of reward, restarts, ties on zero rewards
		apb_write(ADDR_GAIN, 32);
		apb_write(ADDR_ARMS, 3);
		queue_word(CMD_START, 16'hffff);
		queue_word(CMD_REWARD, 16'h7fff);
		queue_word(CMD_REWARD, 16'h8000);
		queue_word(CMD_REWARD, 16'h0000);
		queue_word(CMD_REWARD, 16'h0001);
		queue_word(CMD_REWARD, 16'hffff);
		queue_word(CMD_REWARD, 16'h0100);
		queue_word(CMD_START, 16'h0000);
		for (int i = 0; i < 6; i++)
			queue_word(CMD_REWARD, 16'h0000);
		queue_word(CMD_START, 16'h7fff);
		for (int i = 0; i < 6; i++)
			queue_word(CMD_REWARD, i[0] ? 16'h7fff : 16'h8000);

		// gain extremes, full arm count and out-of-range arm counts
		run_phase(0, 2, 30, 1);
		run_phase(255, 16, 40, 1);
		// last arm may now lie beyond the arms in use
		run_phase(240, 1, 20, 0);
		run_phase(15, 0, 20, 0);
		run_phase(128, 31, 20, 1);

		// receiver holds off for a long stretch while words keep coming
		calm_in = 1;
		run_phase(32, 1, 60, 1);
		hold_req = 1;
		wait_drained();
		calm_in = 0;

		ph = 0;
		while (words_queued < 2000) begin
			calm_in = (ph % 4 == 1);
			calm_out = (ph % 4 == 1) || (ph % 5 == 3);
			run_phase($urandom_range(0, 255), $urandom_range(1, 4), 100,
				$urandom_range(0, 1));
			ph++;
		end
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (expected_picks.size() > 0)
			errors++;
		if (errors == 0)
			$display("ucb_bandit_arm_selector_tb: PASS");
		else
			$display("ucb_bandit_arm_selector_tb: FAIL");
		$finish;
	end

endmodule
`default_nettype wire
